// ===== rtl/rpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_pkg
// Shared types and constants of the ray polyline clipper.
// ----------------------------------------------------------------------------
package rpc_pkg;

  localparam int MAX_POINTS_DEF = 1024;
  localparam int COORD_W = 24;
  localparam int IDX_W = 10;
  localparam int CNT_CFG_W = 11;
  localparam int D_W = COORD_W + 1;
  localparam int P_W = 2 * D_W;
  localparam int DEN_W = P_W + 1;
  localparam int QW = 16;
  localparam int T1_W = D_W + QW + 1;
  localparam int N1_W = D_W + QW + 2;
  localparam int PR_W = D_W + QW + 2;
  localparam logic [QW:0] ONE_Q16 = {1'b1, {QW{1'b0}}};

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CLIP = 1'b1;

  typedef struct packed {
    logic                      op;
    logic [IDX_W-1:0]          point_index;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] clipped_x;
    logic signed [COORD_W-1:0] clipped_y;
  } out_item_t;

endpackage

// ===== rtl/rpc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_div_cell
// One registered restoring division step producing one quotient bit.
// ----------------------------------------------------------------------------
module rpc_div_cell #(
  parameter int W  = 8,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_vld,
  input  logic [W-1:0]           i_rem,
  input  logic [W-1:0]           i_div,
  input  logic [rpc_pkg::QW-1:0] i_quo,
  input  logic [SW-1:0]          i_side,
  output logic                   o_vld,
  output logic [W-1:0]           o_rem,
  output logic [W-1:0]           o_div,
  output logic [rpc_pkg::QW-1:0] o_quo,
  output logic [SW-1:0]          o_side
);
  import rpc_pkg::*;

  logic [W:0] rem2;
  logic [W:0] diff;
  logic       ge;

  assign rem2 = {i_rem, 1'b0};
  assign diff = rem2 - {1'b0, i_div};
  assign ge   = rem2 >= {1'b0, i_div};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld <= 1'b0;
    end else begin
      o_vld <= i_vld;
    end
    o_rem  <= ge ? diff[W-1:0] : rem2[W-1:0];
    o_div  <= i_div;
    o_quo  <= {i_quo[QW-2:0], ge};
    o_side <= i_side;
  end

endmodule

// ===== rtl/rpc_div_chain.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpc_div_chain
// A row of division cells computing a fractional quotient one bit per cell.
// ----------------------------------------------------------------------------
module rpc_div_chain #(
  parameter int W  = 8,
  parameter int SW = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   i_vld,
  input  logic [W-1:0]           i_rem,
  input  logic [W-1:0]           i_div,
  input  logic [SW-1:0]          i_side,
  output logic                   o_vld,
  output logic [rpc_pkg::QW-1:0] o_quo,
  output logic [SW-1:0]          o_side,
  output logic                   o_busy
);
  import rpc_pkg::*;

  logic [QW:0]         vld;
  logic [W-1:0]        rem  [QW+1];
  logic [W-1:0]        dv   [QW+1];
  logic [QW-1:0]       quo  [QW+1];
  logic [SW-1:0]       side [QW+1];

  assign vld[0]  = i_vld;
  assign rem[0]  = i_rem;
  assign dv[0]   = i_div;
  assign quo[0]  = '0;
  assign side[0] = i_side;

  for (genvar k = 0; k < QW; k++) begin : g_cell
    rpc_div_cell #(.W(W), .SW(SW)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .i_vld  (vld[k]),
      .i_rem  (rem[k]),
      .i_div  (dv[k]),
      .i_quo  (quo[k]),
      .i_side (side[k]),
      .o_vld  (vld[k+1]),
      .o_rem  (rem[k+1]),
      .o_div  (dv[k+1]),
      .o_quo  (quo[k+1]),
      .o_side (side[k+1])
    );
  end

  assign o_vld  = vld[QW];
  assign o_quo  = quo[QW];
  assign o_side = side[QW];
  assign o_busy = |vld[QW:1];

endmodule

// ===== rtl/ray_polyline_clip_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_polyline_clip_top
// Clips a ray against a stored polyline held in vertex memories.
// ----------------------------------------------------------------------------
// A write transaction stores one vertex when its index is in range. A clip
// transaction reads one vertex per cycle from the vertex memory, then the
// segment pipeline with its two 16-cell divider rows drains before the result
// is presented. A result still held on the output adds its stall cycles. With
// fewer than two vertices the walk is skipped: setup, multiply, then adjust.
// Reset clears control state and point_count; vertex memories are not cleared.
module ray_polyline_clip_top #(
  parameter int MAX_POINTS = rpc_pkg::MAX_POINTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rpc_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rpc_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [rpc_pkg::CNT_CFG_W-1:0] cfg_wdata
);
  import rpc_pkg::*;

  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int SW2 = 2 + 2 * D_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SETUP = 6'b000010,
    ST_WALK  = 6'b000100,
    ST_DRAIN = 6'b001000,
    ST_MUL   = 6'b010000,
    ST_ADJ   = 6'b100000
  } state_t;

  state_t state_r;
  logic [CW-1:0] cnt_r;
  logic [AW-1:0] addr_r;
  logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
  logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r, prev_x_r, prev_y_r;
  logic rd_vld_r, rd_first_r;
  logic signed [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [D_W-1:0] rdx_r, rdy_r;
  logic sel_x_r, d1neg_r;
  logic [T1_W-1:0] dd_r;
  logic [QW:0] best_r;

  logic s2_vld_r;
  logic signed [D_W-1:0] s2_sdx_r, s2_sdy_r, s2_ax_r, s2_ay_r;
  logic s3_vld_r;
  logic signed [P_W-1:0] s3_p1_r, s3_p2_r, s3_p3_r, s3_p4_r;
  logic signed [D_W-1:0] s3_a0_r, s3_sd_r, s4_a0_r, s4_sd_r;
  logic s4_vld_r;
  logic signed [DEN_W-1:0] s4_den_r, s4_num_r;
  logic s5_vld_r;
  logic [DEN_W-1:0] s5_rem_r, s5_div_r;
  logic [SW2-1:0] s5_side_r;

  logic c1_vld, c1_busy;
  logic [QW-1:0] c1_quo;
  logic [SW2-1:0] c1_side;
  logic [QW:0] t2;

  logic s6_vld_r, s6_ok_r;
  logic signed [N1_W-1:0] s6_m_r, s6_a_r;
  logic s7_vld_r, s7_ok_r;
  logic signed [N1_W-1:0] s7_num_r;
  logic s8_vld_r, s8_ok_r;
  logic [T1_W-1:0] s8_rem_r;

  logic c2_vld, c2_busy;
  logic [QW-1:0] c2_quo;
  logic c2_side;

  logic signed [PR_W-1:0] prod_x_r, prod_y_r, adj_x, adj_y;
  logic busy, out_free;
  logic signed [D_W-1:0] d1;
  logic [D_W-1:0] d1_mag;
  logic signed [DEN_W-1:0] den_n, num_n;
  logic ok5, one5;
  logic signed [N1_W-1:0] num1;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid || out_ready;
  assign busy = rd_vld_r | s2_vld_r | s3_vld_r | s4_vld_r | s5_vld_r | c1_busy |
                s6_vld_r | s7_vld_r | s8_vld_r | c2_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cfg_we) begin
      cnt_r <= (cfg_wdata > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(cfg_wdata);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.op == OP_WRITE &&
        32'(in_data.point_index) < MAX_POINTS) begin
      mem_x[AW'(in_data.point_index)] <= in_data.point_x;
      mem_y[AW'(in_data.point_index)] <= in_data.point_y;
    end
    rd_x_r <= mem_x[addr_r];
    rd_y_r <= mem_y[addr_r];
  end

  assign d1 = (rdx_r != '0) ? rdx_r : rdy_r;
  assign d1_mag = d1[D_W-1] ? D_W'(-d1) : D_W'(d1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_valid <= 1'b0;
      rd_vld_r  <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_WALK);
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_data.op == OP_CLIP) begin
            state_r <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          state_r <= (cnt_r < CW'(2)) ? ST_MUL : ST_WALK;
        end
        ST_WALK: begin
          if (CW'(addr_r) == cnt_r - CW'(1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_ADJ;
        end
        ST_ADJ: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state_r   <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign adj_x = prod_x_r + (prod_x_r[PR_W-1] ? PR_W'(65535) : PR_W'(0));
  assign adj_y = prod_y_r + (prod_y_r[PR_W-1] ? PR_W'(65535) : PR_W'(0));

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      sx_r  <= in_data.start_x;
      sy_r  <= in_data.start_y;
      ex_r  <= in_data.end_x;
      ey_r  <= in_data.end_y;
      rdx_r <= D_W'(in_data.end_x) - D_W'(in_data.start_x);
      rdy_r <= D_W'(in_data.end_y) - D_W'(in_data.start_y);
    end
    if (state_r == ST_SETUP) begin
      sel_x_r <= (rdx_r != '0);
      d1neg_r <= d1[D_W-1];
      dd_r    <= T1_W'({d1_mag, {QW{1'b0}}});
      addr_r  <= '0;
    end
    if (state_r == ST_WALK) begin
      addr_r <= addr_r + AW'(1);
    end
    rd_first_r <= (addr_r == '0);
    if (state_r == ST_SETUP) begin
      best_r <= ONE_Q16;
    end else if (c2_vld && c2_side && {1'b0, c2_quo} < best_r) begin
      best_r <= {1'b0, c2_quo};
    end
    if (state_r == ST_MUL) begin
      prod_x_r <= $signed({1'b0, best_r}) * rdx_r;
      prod_y_r <= $signed({1'b0, best_r}) * rdy_r;
    end
    if (state_r == ST_ADJ && out_free) begin
      if (best_r == ONE_Q16) begin
        out_data.clipped_x <= ex_r;
        out_data.clipped_y <= ey_r;
      end else begin
        out_data.clipped_x <= sx_r + adj_x[COORD_W+QW-1:QW];
        out_data.clipped_y <= sy_r + adj_y[COORD_W+QW-1:QW];
      end
    end
  end

  assign den_n = s4_den_r[DEN_W-1] ? -s4_den_r : s4_den_r;
  assign num_n = s4_den_r[DEN_W-1] ? -s4_num_r : s4_num_r;
  assign ok5 = (den_n != '0) && !num_n[DEN_W-1] && (num_n <= den_n);
  assign one5 = (num_n == den_n);
  assign t2 = c1_side[SW2-2] ? ONE_Q16 : {1'b0, c1_quo};
  assign num1 = s6_a_r + s6_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
      s8_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= rd_vld_r && !rd_first_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= c1_vld;
      s7_vld_r <= s6_vld_r;
      s8_vld_r <= s7_vld_r;
    end
    if (rd_vld_r) begin
      prev_x_r <= rd_x_r;
      prev_y_r <= rd_y_r;
    end
    s2_sdx_r <= D_W'(rd_x_r) - D_W'(prev_x_r);
    s2_sdy_r <= D_W'(rd_y_r) - D_W'(prev_y_r);
    s2_ax_r  <= D_W'(prev_x_r) - D_W'(sx_r);
    s2_ay_r  <= D_W'(prev_y_r) - D_W'(sy_r);
    s3_p1_r <= rdx_r * s2_sdy_r;
    s3_p2_r <= rdy_r * s2_sdx_r;
    s3_p3_r <= rdx_r * s2_ay_r;
    s3_p4_r <= rdy_r * s2_ax_r;
    s3_a0_r <= sel_x_r ? s2_ax_r : s2_ay_r;
    s3_sd_r <= sel_x_r ? s2_sdx_r : s2_sdy_r;
    s4_den_r <= DEN_W'(s3_p1_r) - DEN_W'(s3_p2_r);
    s4_num_r <= DEN_W'(s3_p4_r) - DEN_W'(s3_p3_r);
    s4_a0_r  <= s3_a0_r;
    s4_sd_r  <= s3_sd_r;
    s5_div_r  <= den_n;
    s5_rem_r  <= (ok5 && !one5) ? num_n : '0;
    s5_side_r <= {ok5, one5, s4_a0_r, s4_sd_r};
    s6_ok_r <= c1_side[SW2-1];
    s6_a_r  <= N1_W'($signed({c1_side[2*D_W-1:D_W], {QW{1'b0}}}));
    s6_m_r  <= $signed({1'b0, t2}) * $signed(c1_side[D_W-1:0]);
    s7_ok_r  <= s6_ok_r;
    s7_num_r <= d1neg_r ? -num1 : num1;
    s8_ok_r  <= s7_ok_r && !s7_num_r[N1_W-1] && (s7_num_r < $signed({1'b0, dd_r}));
    s8_rem_r <= (s7_ok_r && !s7_num_r[N1_W-1] &&
                 (s7_num_r < $signed({1'b0, dd_r}))) ? T1_W'(s7_num_r) : '0;
  end

  rpc_div_chain #(.W(DEN_W), .SW(SW2)) u_t2_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_vld  (s5_vld_r),
    .i_rem  (s5_rem_r),
    .i_div  (s5_div_r),
    .i_side (s5_side_r),
    .o_vld  (c1_vld),
    .o_quo  (c1_quo),
    .o_side (c1_side),
    .o_busy (c1_busy)
  );

  rpc_div_chain #(.W(T1_W), .SW(1)) u_t1_chain (
    .clk    (clk),
    .rst_n  (rst_n),
    .i_vld  (s8_vld_r),
    .i_rem  (s8_rem_r),
    .i_div  (dd_r),
    .i_side (s8_ok_r),
    .o_vld  (c2_vld),
    .o_quo  (c2_quo),
    .o_side (c2_side),
    .o_busy (c2_busy)
  );

  a_walk_needs_two: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WALK |-> cnt_r >= CW'(2))
    else $error("Segment walk started with fewer than two vertices.");

  a_best_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ADJ |-> best_r <= ONE_Q16)
    else $error("Best ray parameter out of range.");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !busy)
    else $error("Segment pipeline not empty while idle.");

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("State register lost its one-hot code.");

endmodule
